/* design/tmrs_pkg.sv */
package tmrs_pkg;

  localparam int unsigned MAX_KEEP_DEF = 64;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned VAL_W    = 31;
  localparam int unsigned KLIM_W   = 7;
  localparam int unsigned PEN_W    = 31;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned PROD_W   = POS_W + PEN_W;
  localparam int unsigned BEST_W   = 63;
  localparam int unsigned CFG_W    = 31;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY    = 1'b1;

  localparam logic [KLIM_W-1:0] KEEP_LIMIT_RST = 7'd1;

  // Broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic             ins_en;
    logic             evict;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* design/tmrs_cell.sv */
module tmrs_cell import tmrs_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic             occupied_i,
  input  logic             left_gt_i,
  input  logic [VAL_W-1:0] left_val_i,
  input  logic [VAL_W-1:0] right_ins_i,
  output logic [VAL_W-1:0] val_o,
  output logic             gt_o,
  output logic [VAL_W-1:0] ins_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;

  // An empty cell never reports greater-than, so it does not shift its right neighbour.
  assign gt_o = occupied_i && (val_q > ctrl_i.value);

  // Value of this slot once the new word has been inserted.
  always_comb begin
    if (left_gt_i) begin
      ins_o = left_val_i;
    end else if (gt_o || !occupied_i) begin
      ins_o = ctrl_i.value;
    end else begin
      ins_o = val_q;
    end
  end

  // Eviction of the smallest entry shifts the whole chain down by one.
  assign val_d = ctrl_i.evict ? right_ins_i : ins_o;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

/* design/top_m_running_sum_tracker.sv */
// Streaming top-M sum tracker.
// Samples enter on the input channel (in_valid_i / in_ready_o) with a flag that
// marks the first word of a case. Each accepted word produces exactly one
// best_score word on the output channel (out_valid_o / out_ready_i).
// Positive samples are inserted into a sorted chain of MAX_KEEP cells; when the
// chain holds more than the keep limit, the smallest entry drops out of the
// chain and out of the running sum in the same cycle.
// out_valid_o rises once the word has passed the registered stages in order: the
// chain and sum update at the accepting edge, then the position-times-penalty
// multiply, then the best-score compare into the output register.
// One word is accepted per cycle unless a stalled result holds the pipeline;
// the chain insert and the multiplier are each registered.
// The pipeline advances as a whole. While a result waits on a low out_ready_i,
// in_ready_o is low and every stage holds.
// Reset empties the store, clears sum, position and best score, and sets the
// keep limit to 1 and the penalty to 0. Configuration writes via cfg_we_i are
// taken at any edge and are meant to happen while no word is in flight.
module top_m_running_sum_tracker import tmrs_pkg::*; #(
  parameter int unsigned MAX_KEEP = MAX_KEEP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 first_of_case_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BEST_W-1:0]    best_score_o
);

  localparam int unsigned CW    = $clog2(MAX_KEEP + 1);
  localparam int unsigned LW    = (CW > KLIM_W) ? CW : KLIM_W;
  localparam int unsigned SUM_W = VAL_W + CW;

  // Configuration registers.
  logic [KLIM_W-1:0] keep_limit_q;
  logic [PEN_W-1:0]  penalty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_limit_q <= KEEP_LIMIT_RST;
      penalty_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEEP_LIMIT: keep_limit_q <= cfg_data_i[KLIM_W-1:0];
        CFG_PENALTY:    penalty_q    <= cfg_data_i[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake.
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  // Case state.
  logic [CW-1:0]    count_q, count_d, count_eff;
  logic [SUM_W-1:0] sum_q, sum_d, sum_eff;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             positive;
  logic [VAL_W-1:0] value;
  logic [LW-1:0]    lim_ext, lim_eff;
  logic             evict;

  assign positive  = !sample_i[SAMPLE_W-1] && (sample_i != '0);
  assign value     = sample_i[VAL_W-1:0];
  assign count_eff = first_of_case_i ? '0 : count_q;
  assign sum_eff   = first_of_case_i ? '0 : sum_q;

  assign lim_ext = LW'(keep_limit_q);
  assign lim_eff = (lim_ext > LW'(MAX_KEEP)) ? LW'(MAX_KEEP) : lim_ext;
  assign evict   = (LW'(count_eff) >= lim_eff);

  // Sorted chain, ascending from cell 0.
  cell_ctrl_t       cell_ctrl;
  logic [VAL_W-1:0] cell_val [MAX_KEEP];
  logic [VAL_W-1:0] cell_ins [MAX_KEEP];
  logic [MAX_KEEP-1:0] cell_gt;
  logic [MAX_KEEP-1:0] occupied;
  logic [VAL_W-1:0] tail_ins;

  assign cell_ctrl.ins_en = accept && positive;
  assign cell_ctrl.evict  = evict;
  assign cell_ctrl.value  = value;

  // Slot just past the last cell: used only when an eviction shifts the chain down.
  assign tail_ins = cell_gt[MAX_KEEP-1] ? cell_val[MAX_KEEP-1] : value;

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    logic             left_gt;
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_ins;

    assign occupied[g] = (count_eff > CW'(g));

    if (g == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_body
      assign left_gt  = cell_gt[g-1];
      assign left_val = cell_val[g-1];
    end

    if (g == MAX_KEEP - 1) begin : g_last
      assign right_ins = tail_ins;
    end else begin : g_mid
      assign right_ins = cell_ins[g+1];
    end

    tmrs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occupied_i  (occupied[g]),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .right_ins_i (right_ins),
      .val_o       (cell_val[g]),
      .gt_o        (cell_gt[g]),
      .ins_o       (cell_ins[g])
    );
  end

  // The evicted word is whatever lands in cell 0 after insertion.
  always_comb begin
    count_d = count_eff;
    sum_d   = sum_eff;
    if (positive) begin
      if (evict) begin
        sum_d = sum_eff + SUM_W'(value) - SUM_W'(cell_ins[0]);
      end else begin
        count_d = count_eff + 1'b1;
        sum_d   = sum_eff + SUM_W'(value);
      end
    end
  end

  always_comb begin
    if (first_of_case_i) begin
      pos_d = POS_W'(1);
    end else if (&pos_q) begin
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  // Stage 1 is the case state itself plus these flags.
  logic s1_vld_q, s1_clr_q, s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      pos_q    <= '0;
      s1_vld_q <= 1'b0;
      s1_clr_q <= 1'b0;
      s1_pos_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= accept;
      s1_clr_q <= first_of_case_i;
      s1_pos_q <= positive;
      if (accept) begin
        count_q <= count_d;
        sum_q   <= sum_d;
        pos_q   <= pos_d;
      end
    end
  end

  // Stage 2: position times penalty.
  logic              s2_vld_q;
  logic              s2_clr_q, s2_pos_q;
  logic [SUM_W-1:0]  s2_sum_q;
  logic [PROD_W-1:0] s2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (advance) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_clr_q  <= s1_clr_q;
      s2_pos_q  <= s1_pos_q;
      s2_sum_q  <= sum_q;
      s2_prod_q <= PROD_W'(pos_q) * PROD_W'(penalty_q);
    end
  end

  // Stage 3: best score, held in the output register.
  logic [SUM_W-1:0] best_q, best_d, best_base, cand;
  logic             above;

  assign best_base = s2_clr_q ? '0 : best_q;
  assign above     = (PROD_W'(s2_sum_q) > s2_prod_q);
  assign cand      = s2_sum_q - s2_prod_q[SUM_W-1:0];

  always_comb begin
    best_d = best_base;
    if (s2_pos_q && above && (cand > best_base)) begin
      best_d = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      best_q      <= '0;
    end else if (advance) begin
      out_valid_q <= s2_vld_q;
      if (s2_vld_q) begin
        best_q <= best_d;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_score_o = BEST_W'(best_q);

endmodule

/* design/tmrs_checker.sv */
module tmrs_checker import tmrs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [SAMPLE_W-1:0] sample_i,
  input logic                first_of_case_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [BEST_W-1:0]   best_score_o
);

  // A waiting result word must not change or vanish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_score_o))
    else $error("result word changed while stalled");

  // The input side is held exactly while a result word is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // A case that opens with a non-positive sample reports zero when its word reaches the output unstalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && first_of_case_i &&
     (sample_i[SAMPLE_W-1] || sample_i == '0)) ##1 in_ready_o ##1 in_ready_o
    |=> out_valid_o && best_score_o == '0)
    else $error("new case did not restart best score at zero");

endmodule

bind top_m_running_sum_tracker tmrs_checker u_tmrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .sample_i        (sample_i),
  .first_of_case_i (first_of_case_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .best_score_o    (best_score_o)
);
